[hdl/ccdn_pkg.sv]
// shared types, constants and helpers of the calendar day number converter
`default_nettype none

package ccdn_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned DOY_W  = 9;
	localparam int unsigned IDX_W  = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_EPOCH,
		REG_CYCLE_YEARS,
		REG_LEAP_PER_CYCLE,
		REG_YEAR_OFFSET,
		REG_COMMON_DAYS,
		REG_EXTRA_DAYS,
		REG_DAY_OFFSET,
		REG_CENTURY_SKIP
	} reg_index_t;

	localparam logic [WORD_W-1:0] QUAD_CENT_YEARS = 32'd400;
	localparam logic [WORD_W-1:0] CENT_YEARS      = 32'd100;
	localparam logic [WORD_W-1:0] QUAD_CENT_LEAPS = 32'd100 - 32'd3;

	localparam logic [WORD_W-1:0] EPOCH_RST    = 32'hFFF5_A551;
	localparam logic [6:0]        CYCLE_RST    = 7'd4;
	localparam logic [6:0]        LEAPN_RST    = 7'd1;
	localparam logic [8:0]        COMMON_RST   = 9'd365;
	localparam logic [4:0]        EXTRA_RST    = 5'd1;
	localparam logic [6:0]        PER_RST      = 7'd25;
	localparam logic [WORD_W-1:0] P400_RST     = 32'd146097;
	localparam logic [WORD_W-1:0] P100_RST     = 32'd36524;
	localparam logic [WORD_W-1:0] PC_RST       = 32'd1461;

	typedef struct packed {
		logic [WORD_W-1:0] epoch;
		logic [6:0]        cyc;
		logic [6:0]        leapn;
		logic [10:0]       yoff;
		logic [8:0]        common;
		logic [4:0]        extra;
		logic [17:0]       doff;
		logic              skip;
		logic [WORD_W-1:0] p400;
		logic [WORD_W-1:0] p100;
		logic [WORD_W-1:0] pc;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] year;
		logic [DOY_W-1:0]  doy;
		logic [WORD_W-1:0] dn;
		logic [WORD_W-1:0] x;
	} item_t;

	typedef struct packed {
		item_t             it;
		logic [WORD_W-1:0] q1;
	} tag2_t;

	typedef struct packed {
		item_t             it;
		logic [WORD_W-1:0] q1;
		logic [WORD_W-1:0] q2;
	} tag3_t;

	typedef struct packed {
		item_t             it;
		logic [WORD_W-1:0] q1;
		logic [WORD_W-1:0] q2;
		logic [WORD_W-1:0] q3;
	} tag4_t;

	typedef struct packed {
		logic [WORD_W-1:0] year;
		logic [DOY_W-1:0]  doy;
		logic [WORD_W-1:0] dn;
	} res_t;

	typedef struct packed {
		res_t              res;
		logic [WORD_W-1:0] adj;
	} lt5_t;

	function automatic logic [WORD_W-1:0] sext11(input logic [10:0] v);
		return {{(WORD_W-11){v[10]}}, v};
	endfunction

	function automatic logic [WORD_W-1:0] sext18(input logic [17:0] v);
		return {{(WORD_W-18){v[17]}}, v};
	endfunction

endpackage

`default_nettype wire

[hdl/ccdn_div.sv]
// pipelined signed floor divider, one quotient bit per stage
`default_nettype none

module ccdn_div
	import ccdn_pkg::*;
#(
	parameter int unsigned W  = WORD_W,
	parameter int unsigned TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [W-1:0]  dividend,
	input  logic [W-1:0]  divisor,
	input  logic [TW-1:0] tag_in,
	output logic          out_valid,
	output logic [W-1:0]  quot,
	output logic [W-1:0]  rem,
	output logic [TW-1:0] tag_out
);

	logic          valid_s [W+1];
	logic [W-1:0]  rem_s   [W+1];
	logic [W-1:0]  aq_s    [W+1];
	logic [W-1:0]  bmag_s  [W+1];
	logic [W-1:0]  a_s     [W+1];
	logic [W-1:0]  b_s     [W+1];
	logic [TW-1:0] tag_s   [W+1];

	logic          valid_pa;
	logic [W-1:0]  qt_pa, rt_pa, a_pa, b_pa;
	logic [TW-1:0] tag_pa;

	logic          valid_q;
	logic [W-1:0]  quot_q, rem_q, a_q, b_q;
	logic [TW-1:0] tag_q;

	// magnitudes in, truncated quotient out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s[0] <= 1'b0;
		else valid_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		aq_s[0]   <= dividend[W-1] ? -dividend : dividend;
		bmag_s[0] <= divisor[W-1] ? -divisor : divisor;
		a_s[0]    <= dividend;
		b_s[0]    <= divisor;
		tag_s[0]  <= tag_in;
	end

	for (genvar j = 1; j <= W; j++) begin : g_step
		logic [W:0] shifted, diff;

		assign shifted = {rem_s[j-1], aq_s[j-1][W-1]};
		assign diff    = shifted - {1'b0, bmag_s[j-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[j] <= 1'b0;
			else valid_s[j] <= valid_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (!diff[W]) begin
				rem_s[j] <= diff[W-1:0];
				aq_s[j]  <= {aq_s[j-1][W-2:0], 1'b1};
			end else begin
				rem_s[j] <= shifted[W-1:0];
				aq_s[j]  <= {aq_s[j-1][W-2:0], 1'b0};
			end
			bmag_s[j] <= bmag_s[j-1];
			a_s[j]    <= a_s[j-1];
			b_s[j]    <= b_s[j-1];
			tag_s[j]  <= tag_s[j-1];
		end
	end

	// restore signs, remainder follows the dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_pa <= 1'b0;
		else valid_pa <= valid_s[W];
	end

	always_ff @(posedge clk) begin
		qt_pa  <= (a_s[W][W-1] ^ b_s[W][W-1]) ? -aq_s[W] : aq_s[W];
		rt_pa  <= a_s[W][W-1] ? -rem_s[W] : rem_s[W];
		a_pa   <= a_s[W];
		b_pa   <= b_s[W];
		tag_pa <= tag_s[W];
	end

	// floor correction, zero divisor passes the dividend as remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= valid_pa;
	end

	always_ff @(posedge clk) begin
		if (b_pa == '0) begin
			quot_q <= '0;
			rem_q  <= a_pa;
		end else if (rt_pa != '0 && rt_pa[W-1] != b_pa[W-1]) begin
			quot_q <= qt_pa - W'(1);
			rem_q  <= rt_pa + b_pa;
		end else begin
			quot_q <= qt_pa;
			rem_q  <= rt_pa;
		end
		a_q   <= a_pa;
		b_q   <= b_pa;
		tag_q <= tag_pa;
	end

	assign out_valid = valid_q;
	assign quot      = quot_q;
	assign rem       = rem_q;
	assign tag_out   = tag_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> $past(in_valid, W+3))
		else $error("divider result without a request");

	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (W'(quot_q * b_q + rem_q) == a_q))
		else $error("quotient and remainder do not rebuild the dividend");

	a_rem_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && b_q != '0) |-> (rem_q == '0 || rem_q[W-1] == b_q[W-1]))
		else $error("floor remainder has wrong sign");

endmodule

`default_nettype wire

[hdl/ccdn_cfg.sv]
// calendar registers and the cycle lengths derived from them
`default_nettype none

module ccdn_cfg
	import ccdn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [WORD_W-1:0] cfg_data,
	output cfg_t              cfg
);

	logic [WORD_W-1:0] epoch_q;
	logic [6:0]        cyc_q, leapn_q, per_q, per_d;
	logic [10:0]       yoff_q;
	logic [8:0]        common_q;
	logic [4:0]        extra_q;
	logic [17:0]       doff_q;
	logic              skip_q;
	logic [WORD_W-1:0] p400_q, p100_q, pc_q;
	logic [WORD_W-1:0] common_w, extra_w;
	logic [6:0]        per_tab [128];

	function automatic logic [6:0] per_of(input int unsigned c);
		return (c == 0) ? 7'd0 : 7'(CENT_YEARS / 32'(c));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q  <= EPOCH_RST;
			cyc_q    <= CYCLE_RST;
			leapn_q  <= LEAPN_RST;
			yoff_q   <= '0;
			common_q <= COMMON_RST;
			extra_q  <= EXTRA_RST;
			doff_q   <= '0;
			skip_q   <= 1'b1;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_EPOCH:          epoch_q  <= cfg_data;
				REG_CYCLE_YEARS:    cyc_q    <= cfg_data[6:0];
				REG_LEAP_PER_CYCLE: leapn_q  <= cfg_data[6:0];
				REG_YEAR_OFFSET:    yoff_q   <= cfg_data[10:0];
				REG_COMMON_DAYS:    common_q <= cfg_data[8:0];
				REG_EXTRA_DAYS:     extra_q  <= cfg_data[4:0];
				REG_DAY_OFFSET:     doff_q   <= cfg_data[17:0];
				REG_CENTURY_SKIP:   skip_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// cycles of cycle_years that fit in a century, zero for a zero cycle
	for (genvar g = 0; g < 128; g++) begin : g_per
		assign per_tab[g] = per_of(g);
	end

	assign per_d = per_tab[cyc_q];

	assign common_w = {23'd0, common_q};
	assign extra_w  = {27'd0, extra_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_q  <= PER_RST;
			p400_q <= P400_RST;
			p100_q <= P100_RST;
			pc_q   <= PC_RST;
		end else begin
			per_q  <= per_d;
			p400_q <= skip_q ? common_w * QUAD_CENT_YEARS + QUAD_CENT_LEAPS * extra_w : '0;
			p100_q <= skip_q ? common_w * CENT_YEARS + ({25'd0, per_q} - 32'd1) * extra_w : '0;
			pc_q   <= common_w * {25'd0, cyc_q} + {25'd0, leapn_q} * extra_w;
		end
	end

	always_comb begin
		cfg.epoch  = epoch_q;
		cfg.cyc    = cyc_q;
		cfg.leapn  = leapn_q;
		cfg.yoff   = yoff_q;
		cfg.common = common_q;
		cfg.extra  = extra_q;
		cfg.doff   = doff_q;
		cfg.skip   = skip_q;
		cfg.p400   = p400_q;
		cfg.p100   = p100_q;
		cfg.pc     = pc_q;
	end

endmodule

`default_nettype wire

[hdl/cyclic_calendar_day_number_convert.sv]
// top level: day number <-> year and day of year for a leap-cycle calendar
`default_nettype none

// Takes one request per cycle (busy stays low) and returns each result with a one-cycle
// done strobe; the receiver cannot hold results off. A request passes through five chained
// floor dividers: four for the year/day split or the leap-day counts, one for the cycle
// remainder in the leap test of the result year, plus registered stages of adders,
// multipliers and the century divisibility test. The cycle lengths derived from the
// configuration are registered from the written values; write only while no
// request is in flight.
module cyclic_calendar_day_number_convert
	import ccdn_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     kind,
	input  logic signed [WORD_W-1:0] year_in,
	input  logic [DOY_W-1:0]         day_of_year_in,
	input  logic signed [WORD_W-1:0] day_number_in,
	input  logic                     cfg_we,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [WORD_W-1:0]        cfg_data,
	output logic                     busy,
	output logic                     done,
	output logic signed [WORD_W-1:0] year_out,
	output logic [DOY_W-1:0]         day_of_year_out,
	output logic signed [WORD_W-1:0] day_number_out,
	output logic                     leap_year
);

	// 2^10 is -1 mod 25; bias keeps the folded sum positive, reciprocal of 25 over 2^15
	localparam logic [11:0] FOLD_BIAS = 12'd1050;
	localparam logic [22:0] RECIP_25  = 23'd1311;

	cfg_t cfg;
	logic [WORD_W-1:0] cyc_w, leapn_w, common_w, extra_w;

	logic  v_s1;
	item_t it_s1;

	logic d1_v, d2_v, d3_v, d4_v, d5_v;
	logic [WORD_W-1:0] q1, r1, q2, r2, q3, r3, q4, r4, r5;
	item_t t1;
	tag2_t t2;
	tag3_t t3;
	tag4_t t4;
	lt5_t  t5;
	tag2_t t2_in;
	tag3_t t3_in;
	tag4_t t4_in;
	lt5_t  t5_in;

	logic              v_s2, kind_s2, flag_s2;
	res_t              res_s2;
	logic [WORD_W-1:0] a_s2, b_s2, c_s2, ry_s2;

	logic              v_s3, kind_s3, flag_s3;
	res_t              res_s3;
	logic [WORD_W-1:0] p_s3, m1_s3, m2_s3;

	logic v_s4, v_s5;
	res_t res_s4, res_s5;
	logic [WORD_W-1:0] adj_s5;

	logic        v_s6, z4_s6, z16_s6, simple_s6;
	res_t        res_s6;
	logic [11:0] fold_s6;
	logic [22:0] recip_prod;
	logic [7:0]  q25;
	logic [11:0] rem25;

	logic v_s7, simple_s7, z100_s7, z400_s7;
	res_t res_s7;

	logic              done_q, leap_q;
	res_t              res_q;

	assign busy = 1'b0;

	ccdn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign cyc_w    = {25'd0, cfg.cyc};
	assign leapn_w  = {25'd0, cfg.leapn};
	assign common_w = {23'd0, cfg.common};
	assign extra_w  = {27'd0, cfg.extra};

	// request register: offset years or offset day count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		it_s1.kind <= kind;
		it_s1.year <= year_in;
		it_s1.doy  <= day_of_year_in;
		it_s1.dn   <= day_number_in;
		it_s1.x    <= kind ? day_number_in - cfg.epoch - sext18(cfg.doff)
		                   : year_in - 32'd1 - sext11(cfg.yoff);
	end

	// kind 1: split by 400-year, century, leap cycle, common year
	// kind 0: divide offset years by cycle, 100 and 400
	ccdn_div #(.W(WORD_W), .TW($bits(item_t))) u_div1 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1),
		.dividend(it_s1.x), .divisor(it_s1.kind ? cfg.p400 : cyc_w), .tag_in(it_s1),
		.out_valid(d1_v), .quot(q1), .rem(r1), .tag_out(t1)
	);

	assign t2_in = '{it: t1, q1: q1};

	ccdn_div #(.W(WORD_W), .TW($bits(tag2_t))) u_div2 (
		.clk(clk), .arst_n(arst_n), .in_valid(d1_v),
		.dividend(t1.kind ? r1 : t1.x), .divisor(t1.kind ? cfg.p100 : CENT_YEARS),
		.tag_in(t2_in),
		.out_valid(d2_v), .quot(q2), .rem(r2), .tag_out(t2)
	);

	assign t3_in = '{it: t2.it, q1: t2.q1, q2: q2};

	ccdn_div #(.W(WORD_W), .TW($bits(tag3_t))) u_div3 (
		.clk(clk), .arst_n(arst_n), .in_valid(d2_v),
		.dividend(t2.it.kind ? r2 : t2.it.x),
		.divisor(t2.it.kind ? cfg.pc : QUAD_CENT_YEARS), .tag_in(t3_in),
		.out_valid(d3_v), .quot(q3), .rem(r3), .tag_out(t3)
	);

	assign t4_in = '{it: t3.it, q1: t3.q1, q2: t3.q2, q3: q3};

	ccdn_div #(.W(WORD_W), .TW($bits(tag4_t))) u_div4 (
		.clk(clk), .arst_n(arst_n), .in_valid(d3_v),
		.dividend(r3), .divisor(common_w), .tag_in(t4_in),
		.out_valid(d4_v), .quot(q4), .rem(r4), .tag_out(t4)
	);

	// products: year parts for kind 1, day counts for kind 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= d4_v;
	end

	always_ff @(posedge clk) begin
		kind_s2    <= t4.it.kind;
		res_s2     <= '{year: t4.it.year, doy: t4.it.doy, dn: t4.it.dn};
		ry_s2      <= r4;
		flag_s2    <= (t4.q2 == cyc_w) || (q4 == cyc_w);
		if (t4.it.kind) begin
			a_s2 <= QUAD_CENT_YEARS * t4.q1 + CENT_YEARS * t4.q2;
			b_s2 <= cyc_w * t4.q3;
			c_s2 <= q4;
		end else begin
			a_s2 <= t4.it.x * common_w;
			b_s2 <= leapn_w * t4.q1;
			c_s2 <= t4.q3 - t4.q2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		kind_s3     <= kind_s2;
		flag_s3     <= flag_s2;
		res_s3.year <= res_s2.year;
		res_s3.dn   <= res_s2.dn;
		if (kind_s2) begin
			p_s3       <= a_s2 + b_s2 + c_s2 + sext11(cfg.yoff);
			res_s3.doy <= flag_s2 ? DOY_W'(common_w + extra_w) : DOY_W'(ry_s2 + 32'd1);
			m1_s3      <= '0;
			m2_s3      <= '0;
		end else begin
			p_s3       <= a_s2 + sext18(cfg.doff) + cfg.epoch - 32'd1
			              + {{(WORD_W-DOY_W){1'b0}}, res_s2.doy};
			res_s3.doy <= res_s2.doy;
			m1_s3      <= b_s2 * extra_w;
			m2_s3      <= cfg.skip ? c_s2 * extra_w : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		res_s4.doy <= res_s3.doy;
		if (kind_s3) begin
			res_s4.year <= flag_s3 ? p_s3 : p_s3 + 32'd1;
			res_s4.dn   <= res_s3.dn;
		end else begin
			res_s4.year <= res_s3.year;
			res_s4.dn   <= p_s3 + m1_s3 + m2_s3;
		end
	end

	// leap test of the result year
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		res_s5 <= res_s4;
		adj_s5 <= leapn_w * res_s4.year - sext11(cfg.yoff);
	end

	assign t5_in = '{res: res_s5, adj: adj_s5};

	ccdn_div #(.W(WORD_W), .TW($bits(lt5_t))) u_div5 (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s5),
		.dividend(adj_s5), .divisor(cyc_w), .tag_in(t5_in),
		.out_valid(d5_v), .quot(), .rem(r5), .tag_out(t5)
	);

	// century test: 100 = 4 * 25 and 400 = 16 * 25, fold the word mod 25
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= d5_v;
	end

	always_ff @(posedge clk) begin
		res_s6    <= t5.res;
		simple_s6 <= $signed(r5) < $signed(leapn_w);
		z4_s6     <= (t5.adj[1:0] == 2'd0);
		z16_s6    <= (t5.adj[3:0] == 4'd0);
		// sign weight 2^32 is -4 mod 25
		fold_s6   <= {2'd0, t5.adj[9:0]} + {2'd0, t5.adj[29:20]} + FOLD_BIAS
		             + {9'd0, t5.adj[31], 2'd0} - {2'd0, t5.adj[19:10]}
		             - {10'd0, t5.adj[31:30]};
	end

	assign recip_prod = {11'd0, fold_s6} * RECIP_25;
	assign q25        = recip_prod[22:15];
	assign rem25      = fold_s6 - {4'd0, q25} * 12'd25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		res_s7    <= res_s6;
		simple_s7 <= simple_s6;
		z100_s7   <= (rem25 == 12'd0) && z4_s6;
		z400_s7   <= (rem25 == 12'd0) && z16_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= v_s7;
	end

	always_ff @(posedge clk) begin
		res_q  <= res_s7;
		leap_q <= simple_s7 && (!cfg.skip || !z100_s7 || z400_s7);
	end

	assign done            = done_q;
	assign year_out        = res_q.year;
	assign day_of_year_out = res_q.doy;
	assign day_number_out  = res_q.dn;
	assign leap_year       = leap_q;

endmodule

`default_nettype wire

[tb/sv/ccdn_checker.sv]
// checker: watches requests and results, predicts conversions and compares them
`timescale 1ns / 100ps

module ccdn_checker
	import ccdn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              kind,
	input  logic [31:0]       year_in,
	input  logic [8:0]        day_of_year_in,
	input  logic [31:0]       day_number_in,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              done,
	input  logic [31:0]       year_out,
	input  logic [8:0]        day_of_year_out,
	input  logic [31:0]       day_number_out,
	input  logic              leap_year,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [31:0] year;
		logic [8:0]  doy;
		logic [31:0] dn;
		logic        leap;
	} conv_t;

	conv_t       expected_q[$];
	logic [31:0] c_epoch;
	logic [6:0]  c_cyc;
	logic [6:0]  c_leapn;
	logic [10:0] c_yoff;
	logic [8:0]  c_common;
	logic [4:0]  c_extra;
	logic [17:0] c_doff;
	logic        c_skip;

	assign pending = expected_q.size();

	// floor division; zero divisor gives quotient 0, remainder = dividend
	function automatic void div_floor(input logic [31:0] a, input logic [31:0] b,
			output logic [31:0] q, output logic [31:0] r);
		longint qq, rr;
		if (b == 0) begin
			q = 0;
			r = a;
			return;
		end
		qq = longint'($signed(a)) / longint'($signed(b));
		rr = longint'($signed(a)) % longint'($signed(b));
		if (rr != 0 && ((rr < 0) != ($signed(b) < 0))) begin
			qq--;
			rr += longint'($signed(b));
		end
		q = qq[31:0];
		r = rr[31:0];
	endfunction

	function automatic logic is_leap(input logic [31:0] year);
		logic [31:0] adj, q, r, r100, r400;
		logic        simple;
		adj = {25'd0, c_leapn} * year - sext11(c_yoff);
		div_floor(adj, {25'd0, c_cyc}, q, r);
		simple = $signed(r) < $signed({25'd0, c_leapn});
		if (!c_skip)
			return simple;
		div_floor(adj, 32'd100, q, r100);
		div_floor(adj, 32'd400, q, r400);
		return simple && (r100 != 0 || r400 == 0);
	endfunction

	function automatic conv_t convert(input logic k, input logic [31:0] yr,
			input logic [8:0] doy, input logic [31:0] dn);
		conv_t       c;
		logic [31:0] off, ld, q, r, q100, q400, r400, r100, qc, rc, qy, ry, y, per, total, dd;
		dd = 32'd0;
		if (k == 1'b0) begin
			off = yr - 32'd1 - sext11(c_yoff);
			div_floor(off, {25'd0, c_cyc}, q, r);
			ld = {25'd0, c_leapn} * q * {27'd0, c_extra};
			if (c_skip) begin
				div_floor(off, 32'd100, q100, r);
				div_floor(off, 32'd400, q400, r);
				ld += (q400 - q100) * {27'd0, c_extra};
			end
			dn = off * {23'd0, c_common} + ld + sext18(c_doff) + c_epoch - 32'd1 + {23'd0, doy};
		end else begin
			total = dn - c_epoch - sext18(c_doff);
			q400 = 0;
			r400 = 0;
			q100 = 0;
			r100 = total;
			if (c_skip) begin
				per = (c_cyc == 0) ? 32'd0 : 32'd100 / {25'd0, c_cyc};
				div_floor(total, {23'd0, c_common} * 32'd400 + 32'd97 * {27'd0, c_extra},
					q400, r400);
				div_floor(r400, {23'd0, c_common} * 32'd100 + (per - 32'd1) * {27'd0, c_extra},
					q100, r100);
			end
			div_floor(r100, {23'd0, c_common} * {25'd0, c_cyc}
				+ {25'd0, c_leapn} * {27'd0, c_extra}, qc, rc);
			div_floor(rc, {23'd0, c_common}, qy, ry);
			y = 32'd400 * q400 + 32'd100 * q100 + {25'd0, c_cyc} * qc + qy + sext11(c_yoff);
			if (q100 == {25'd0, c_cyc} || qy == {25'd0, c_cyc}) begin
				dd = {23'd0, c_common} + {27'd0, c_extra};
			end else begin
				y++;
				dd = ry + 32'd1;
			end
			yr = y;
			doy = dd[8:0];
		end
		c.year = yr;
		c.doy = doy;
		c.dn = dn;
		c.leap = is_leap(yr);
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		conv_t e;
		if (!arst_n) begin
			c_epoch <= EPOCH_RST;
			c_cyc <= CYCLE_RST;
			c_leapn <= LEAPN_RST;
			c_yoff <= '0;
			c_common <= COMMON_RST;
			c_extra <= EXTRA_RST;
			c_doff <= '0;
			c_skip <= 1'b1;
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (start && !busy)
				expected_q.push_back(convert(kind, year_in, day_of_year_in, day_number_in));
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (year_out !== e.year) begin
						$error("year_out exp %0d got %0d", $signed(e.year), $signed(year_out));
						fail_count <= fail_count + 1;
					end
					if (day_of_year_out !== e.doy) begin
						$error("day_of_year_out exp %0d got %0d", e.doy, day_of_year_out);
						fail_count <= fail_count + 1;
					end
					if (day_number_out !== e.dn) begin
						$error("day_number_out exp %0d got %0d", $signed(e.dn),
							$signed(day_number_out));
						fail_count <= fail_count + 1;
					end
					if (leap_year !== e.leap) begin
						$error("leap_year exp %0d got %0d", e.leap, leap_year);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_EPOCH:          c_epoch <= cfg_data;
					REG_CYCLE_YEARS:    c_cyc <= cfg_data[6:0];
					REG_LEAP_PER_CYCLE: c_leapn <= cfg_data[6:0];
					REG_YEAR_OFFSET:    c_yoff <= cfg_data[10:0];
					REG_COMMON_DAYS:    c_common <= cfg_data[8:0];
					REG_EXTRA_DAYS:     c_extra <= cfg_data[4:0];
					REG_DAY_OFFSET:     c_doff <= cfg_data[17:0];
					REG_CENTURY_SKIP:   c_skip <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/sv/testbench.sv]
// testbench top: drives conversion requests and calendar settings, gives the verdict
`timescale 1ns / 100ps

module testbench;
	import ccdn_pkg::*;

	localparam int LATENCY = 183;
	localparam int WATCHDOG = 5000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              kind = 1'b0;
	logic [31:0]       year_in = '0;
	logic [8:0]        day_of_year_in = '0;
	logic [31:0]       day_number_in = '0;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [31:0]       cfg_data = '0;
	logic              busy, done, leap_year;
	logic [31:0]       year_out, day_number_out;
	logic [8:0]        day_of_year_out;
	int                fail_count, pending, quiet;
	int                send_idle_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cyclic_calendar_day_number_convert dut (
		.clk, .arst_n, .start, .kind, .year_in, .day_of_year_in, .day_number_in,
		.cfg_we, .cfg_index, .cfg_data, .busy, .done, .year_out, .day_of_year_out,
		.day_number_out, .leap_year
	);

	ccdn_checker chk (
		.clk, .arst_n, .start, .busy, .kind, .year_in, .day_of_year_in, .day_number_in,
		.cfg_we, .cfg_index, .cfg_data, .done, .year_out, .day_of_year_out,
		.day_number_out, .leap_year, .fail_count, .pending
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// one request, held until accepted, with optional idle cycles before it
	task automatic send(input logic k, input logic [31:0] yr, input logic [8:0] d,
			input logic [31:0] dn);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		year_in <= yr;
		day_of_year_in <= d;
		day_number_in <= dn;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_calendar(input logic [31:0] ep, input logic [6:0] cy,
			input logic [6:0] ln, input logic [10:0] yo, input logic [8:0] cm,
			input logic [4:0] ex, input logic [17:0] dof, input logic sk);
		write_reg(REG_EPOCH, ep);
		write_reg(REG_CYCLE_YEARS, {25'd0, cy});
		write_reg(REG_LEAP_PER_CYCLE, {25'd0, ln});
		write_reg(REG_YEAR_OFFSET, {21'd0, yo});
		write_reg(REG_COMMON_DAYS, {23'd0, cm});
		write_reg(REG_EXTRA_DAYS, {27'd0, ex});
		write_reg(REG_DAY_OFFSET, {14'd0, dof});
		write_reg(REG_CENTURY_SKIP, {31'd0, sk});
		@(posedge clk);
	endtask

	// mostly plausible years and day numbers, sometimes the whole range
	task automatic random_request();
		logic [31:0] yr, dn;
		yr = ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(8000)) - 4000);
		dn = ($urandom_range(3) == 0) ? $urandom
			: 32'($signed($urandom_range(3000000)) - 1500000);
		send($urandom_range(1), yr, ($urandom_range(7) == 0) ? 9'($urandom)
			: 9'($urandom_range(1, 366)), dn);
	endtask

	initial begin
		send_idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and leap boundaries with reset calendar
		send(1'b0, 32'd2000, 9'd60, '0);
		send(1'b0, 32'd1900, 9'd365, '0);
		send(1'b0, 32'd1, 9'd1, '0);
		send(1'b0, 32'h8000_0000, 9'd0, '0);
		send(1'b0, 32'h7FFF_FFFF, 9'd511, '0);
		send(1'b0, 32'hFFFF_FFFF, 9'd366, '0);
		send(1'b1, '0, '0, 32'hFFF5_A551);
		send(1'b1, '0, '0, 32'hFFF5_A550);
		send(1'b1, '0, '0, 32'd51544);
		send(1'b1, '0, '0, 32'h8000_0000);
		send(1'b1, '0, '0, 32'h7FFF_FFFF);
		send(1'b1, '0, '0, 32'hFFFF_FFFF);
		drain();

		// zero divisors and wide day counts
		set_calendar(32'h8000_0000, 7'd0, 7'd127, 11'h400, 9'd0, 5'd31, 18'h20000, 1'b1);
		send(1'b0, 32'd5, 9'd3, '0);
		send(1'b1, '0, '0, 32'd12345);
		send(1'b1, '0, '0, 32'h8000_0000);
		drain();
		set_calendar(32'h7FFF_FFFF, 7'd100, 7'd100, 11'h3FF, 9'd400, 5'd31, 18'h1FFFF, 1'b0);
		send(1'b0, 32'd7, 9'd500, '0);
		send(1'b1, '0, '0, 32'h7FFF_0000);
		send(1'b1, '0, '0, 32'hFFFF_FFFF);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 86 : 0;
			case (ph)
				0: set_calendar(EPOCH_RST, 7'd4, 7'd1, '0, 9'd365, 5'd1, '0, 1'b1);
				1: set_calendar(32'd0, 7'd33, 7'd8, 11'h7E0, 9'd365, 5'd1, 18'd500, 1'b0);
				2: set_calendar($urandom, 7'd1, 7'd0, 11'd1000, 9'd1, 5'd0, 18'h3C000, 1'b1);
				3: set_calendar(32'd1721426, 7'd19, 7'd7, 11'd3, 9'd354, 5'd30, 18'd7, 1'b0);
				default: set_calendar($urandom, 7'($urandom_range(1, 100)),
					7'($urandom_range(100)), 11'($urandom), 9'($urandom_range(1, 400)),
					5'($urandom), 18'($urandom), 1'($urandom));
			endcase
			for (int i = 0; i < 270; i++) begin
				random_request();
				// sender holds off until the pipeline is empty
				if (i == 100) begin
					start <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
